@@ design/mbh_pkg.sv @@
// ----------------------------------------------------------------------------
// mbh_pkg
// Types, codes and constants shared by the histogram core and its remainder
// unit.
// ----------------------------------------------------------------------------
package mbh_pkg;

  localparam int unsigned MAX_BINS_DEF = 16;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned BIN_IDX_W    = 4;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned ACT_W        = 2;
  localparam int unsigned ST_W         = 2;
  localparam int unsigned CFG_AW       = 3;
  localparam int unsigned CFG_DW       = 32;
  localparam int unsigned DIG_W        = 4;
  localparam int unsigned MOD_STEPS    = VAL_W / DIG_W;
  localparam int unsigned STEP_W       = $clog2(MOD_STEPS);

  localparam logic [CNT_W-1:0] BIN_COUNT_RST = CNT_W'(10);

  // request actions
  localparam logic [ACT_W-1:0] ACT_ADD   = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_CLEAR = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_DUMP  = ACT_W'(2);

  // result status
  localparam logic [ST_W-1:0] ST_COUNTED  = ST_W'(0);
  localparam logic [ST_W-1:0] ST_REJECTED = ST_W'(1);
  localparam logic [ST_W-1:0] ST_CLEARED  = ST_W'(2);
  localparam logic [ST_W-1:0] ST_DUMP     = ST_W'(3);

  // register word index
  localparam logic REG_BIN_COUNT = 1'b0;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [VAL_W-1:0] sample_bits;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [BIN_IDX_W-1:0] bin_index;
    logic [VAL_W-1:0]     bin_value;
    logic                 last;
  } out_item_t;

endpackage

@@ design/modulo_bin_histogram_core.sv @@
// ----------------------------------------------------------------------------
// modulo_bin_histogram_core
// Histogram engine: float samples truncated to an integer bin modulo the
// bin count, saturating counters in a synchronous memory, clear and dump.
// ----------------------------------------------------------------------------
// add: remainder unit, then read-modify-write of the counter memory;
//   one request at a time; a value equal to the bin count goes to the last bin
// rejected sample and clear: one result; dump: one result per bin in use
// reset clears the control state and all bin valid bits (bins read as zero)
//   at once, with no clearing pass; bin_count resets to 10
// ----------------------------------------------------------------------------
module modulo_bin_histogram_core #(
  parameter int unsigned MAX_BINS = mbh_pkg::MAX_BINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mbh_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mbh_pkg::out_item_t           out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mbh_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [mbh_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [mbh_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import mbh_pkg::*;

  localparam int unsigned IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MOD  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_WB   = 7'b0001000,
    S_OUT  = 7'b0010000,
    S_DRD  = 7'b0100000,
    S_DOUT = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    addr_r, addr_nxt;
  logic                eq_r, eq_nxt;
  out_item_t           res_r, res_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MAX_BINS-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0]    bc_r, bc_nxt;
  logic [VAL_W-1:0]    rdata_r;
  logic [VAL_W-1:0]    mem [MAX_BINS];

  logic [CNT_W-1:0]    n_eff;
  logic                cfg_wr;
  logic                out_free;
  logic                push;
  out_item_t           push_item;
  logic                rd_en, wr_en;
  logic [VAL_W-1:0]    cur_val, inc_val;
  logic                dump_last;

  logic                smp_sign;
  logic [7:0]          smp_expo;
  logic [7:0]          smp_e;
  logic [VAL_W-1:0]    smp_mant;
  logic [VAL_W-1:0]    smp_t;
  logic                smp_rej;

  logic                mod_start;
  logic                mod_done;
  logic [CNT_W-1:0]    mod_rem;

  // configuration
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_BIN_COUNT) ? CFG_DW'(bc_r) : '0;

  always_comb begin
    bc_nxt = bc_r;
    if (cfg_wr && (cfg_paddr[2] == REG_BIN_COUNT)) begin
      bc_nxt = cfg_pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (bc_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(bc_r) > MAX_BINS) begin
      n_eff = CNT_W'(MAX_BINS);
    end else begin
      n_eff = bc_r;
    end
  end

  // float to integer, truncated toward zero
  always_comb begin
    smp_sign = in_data.sample_bits[31];
    smp_expo = in_data.sample_bits[30:23];
    smp_e    = smp_expo - 8'd127;
    smp_mant = {8'b0, 1'b1, in_data.sample_bits[22:0]};
    smp_rej  = (smp_expo == 8'hFF)
            || ((smp_expo >= 8'd127) && smp_sign)
            || (smp_expo >= 8'd158);
    if (smp_expo < 8'd127) begin
      smp_t = '0;
    end else if (smp_e >= 8'd23) begin
      smp_t = smp_mant << (smp_e[4:0] - 5'd23);
    end else begin
      smp_t = smp_mant >> (5'd23 - smp_e[4:0]);
    end
  end

  mbh_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (smp_t),
    .divisor  (n_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign cur_val   = vld_r[addr_r] ? rdata_r : '0;
  assign inc_val   = (cur_val == '1) ? cur_val : cur_val + VAL_W'(1);
  assign dump_last = (CMP_W'(addr_r) == CMP_W'(n_eff - 1'b1));
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    eq_nxt    = eq_r;
    res_nxt   = res_r;
    vld_nxt   = vld_r;
    push      = 1'b0;
    push_item = res_r;
    mod_start = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.action)
            ACT_ADD: begin
              if (smp_rej) begin
                res_nxt.status    = ST_REJECTED;
                res_nxt.bin_index = '0;
                res_nxt.bin_value = '0;
                res_nxt.last      = 1'b1;
                state_nxt         = S_OUT;
              end else begin
                mod_start = 1'b1;
                eq_nxt    = (smp_t == VAL_W'(n_eff));
                state_nxt = S_MOD;
              end
            end
            ACT_CLEAR: begin
              vld_nxt           = '0;
              res_nxt.status    = ST_CLEARED;
              res_nxt.bin_index = '0;
              res_nxt.bin_value = '0;
              res_nxt.last      = 1'b1;
              state_nxt         = S_OUT;
            end
            ACT_DUMP: begin
              addr_nxt  = '0;
              state_nxt = S_DRD;
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          addr_nxt  = eq_r ? IDX_W'(n_eff - 1'b1) : IDX_W'(mod_rem);
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        wr_en             = 1'b1;
        vld_nxt[addr_r]   = 1'b1;
        res_nxt.status    = ST_COUNTED;
        res_nxt.bin_index = BIN_IDX_W'(addr_r);
        res_nxt.bin_value = inc_val;
        res_nxt.last      = 1'b1;
        state_nxt         = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DRD: begin
        rd_en     = 1'b1;
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        push_item.status    = ST_DUMP;
        push_item.bin_index = BIN_IDX_W'(addr_r);
        push_item.bin_value = cur_val;
        push_item.last      = dump_last;
        if (out_free) begin
          push = 1'b1;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            addr_nxt  = IDX_W'(addr_r + 1'b1);
            state_nxt = S_DRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_nxt       = push_item;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      bc_r        <= BIN_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      bc_r        <= bc_nxt;
    end
    addr_r <= addr_nxt;
    eq_r   <= eq_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // counter memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= inc_val;
    end
    if (rd_en) begin
      rdata_r <= mem[addr_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ design/mbh_mod.sv @@
// ----------------------------------------------------------------------------
// mbh_mod
// Iterative remainder unit: reduces a 32-bit value modulo a small divisor,
// four dividend bits per cycle, most significant first.
// ----------------------------------------------------------------------------
module mbh_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mbh_pkg::VAL_W-1:0]   dividend,
  input  logic [mbh_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [mbh_pkg::CNT_W-1:0]   rem
);
  import mbh_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [VAL_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;

  always_comb begin
    logic [CNT_W:0] acc;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    acc      = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      acc = {1'b0, rem_r};
      for (int k = 0; k < DIG_W; k++) begin
        acc = {acc[CNT_W-1:0], quo_r[VAL_W-1-k]};
        if (acc >= {1'b0, divisor}) begin
          acc = acc - {1'b0, divisor};
        end
      end
      rem_nxt = acc[CNT_W-1:0];
      quo_nxt = quo_r << DIG_W;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ dv/tb_modulo_bin_histogram_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modulo_bin_histogram_core
// Self-checking bench for the histogram core. A table of directed requests
// is followed by random phases, each under its own bin count. Every accepted
// request is run through a bin-count predictor, and each result is checked
// field by field against the oldest expected one. Both handshakes idle in
// random bursts, and one phase holds off the result side for a long stretch.
// ----------------------------------------------------------------------------
module tb_modulo_bin_histogram_core;
  import mbh_pkg::*;

  localparam int unsigned N_DIR           = 24;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned REQS_PER_PHASE  = 13;
  localparam int unsigned LONG_HOLD_CYC   = 300;
  localparam int unsigned DRAIN_CYC       = 60;
  localparam int unsigned MAX_REPORTS     = 10;

  localparam logic [CFG_AW-1:0] ADDR_BIN_COUNT = {REG_BIN_COUNT, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED  = {~REG_BIN_COUNT, 2'b00};
  localparam logic [ACT_W-1:0]  ACT_NONE       = ACT_W'(3);

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  localparam out_item_t NO_RES = out_item_t'('0);

  // bin count is 10 after reset
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{'{ACT_DUMP,  32'h0000_0000}, 1'b0, NO_RES},
    '{'{ACT_ADD,   32'h0000_0000}, 1'b1, '{ST_COUNTED,  4'd0, 32'd1, 1'b1}},
    '{'{ACT_ADD,   32'h8000_0000}, 1'b1, '{ST_COUNTED,  4'd0, 32'd2, 1'b1}},
    '{'{ACT_ADD,   32'hBF00_0000}, 1'b1, '{ST_COUNTED,  4'd0, 32'd3, 1'b1}},
    '{'{ACT_ADD,   32'h0000_0001}, 1'b1, '{ST_COUNTED,  4'd0, 32'd4, 1'b1}},
    '{'{ACT_ADD,   32'h807F_FFFF}, 1'b1, '{ST_COUNTED,  4'd0, 32'd5, 1'b1}},
    '{'{ACT_ADD,   32'h3F7F_FFFF}, 1'b1, '{ST_COUNTED,  4'd0, 32'd6, 1'b1}},
    '{'{ACT_ADD,   32'h7FC0_0000}, 1'b1, '{ST_REJECTED, 4'd0, 32'd0, 1'b1}},
    '{'{ACT_ADD,   32'h7F80_0000}, 1'b1, '{ST_REJECTED, 4'd0, 32'd0, 1'b1}},
    '{'{ACT_ADD,   32'hFF80_0000}, 1'b1, '{ST_REJECTED, 4'd0, 32'd0, 1'b1}},
    '{'{ACT_ADD,   32'hFFFF_FFFF}, 1'b1, '{ST_REJECTED, 4'd0, 32'd0, 1'b1}},
    '{'{ACT_ADD,   32'hBF80_0000}, 1'b1, '{ST_REJECTED, 4'd0, 32'd0, 1'b1}},
    '{'{ACT_ADD,   32'h4F00_0000}, 1'b1, '{ST_REJECTED, 4'd0, 32'd0, 1'b1}},
    '{'{ACT_ADD,   32'h7F7F_FFFF}, 1'b1, '{ST_REJECTED, 4'd0, 32'd0, 1'b1}},
    '{'{ACT_ADD,   32'h4EFF_FFFF}, 1'b0, NO_RES},
    '{'{ACT_ADD,   32'h3F80_0000}, 1'b1, '{ST_COUNTED,  4'd1, 32'd1, 1'b1}},
    '{'{ACT_ADD,   32'h4120_0000}, 1'b1, '{ST_COUNTED,  4'd9, 32'd1, 1'b1}},
    '{'{ACT_ADD,   32'h4130_0000}, 1'b0, NO_RES},
    '{'{ACT_ADD,   32'h4B7F_FFFF}, 1'b0, NO_RES},
    '{'{ACT_NONE,  32'hFFFF_FFFF}, 1'b0, NO_RES},
    '{'{ACT_DUMP,  32'hFFFF_FFFF}, 1'b0, NO_RES},
    '{'{ACT_CLEAR, 32'h0000_0000}, 1'b1, '{ST_CLEARED,  4'd0, 32'd0, 1'b1}},
    '{'{ACT_DUMP,  32'h0000_0000}, 1'b0, NO_RES},
    '{'{ACT_ADD,   32'h40A0_0000}, 1'b1, '{ST_COUNTED,  4'd5, 32'd1, 1'b1}}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  logic [VAL_W-1:0]  bin_model [MAX_BINS_DEF];
  logic [CNT_W-1:0]  bin_count_model;
  out_item_t         pred_results [$];
  out_item_t         exp_results [$];
  out_item_t         want;
  int unsigned       n_mismatch = 0;
  bit                quiet = 1'b0;
  bit                long_hold = 1'b0;
  int unsigned       sender_idle_pct = 20;
  int unsigned       ready_idle_pct = 15;

  modulo_bin_histogram_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  function automatic void flag(input string msg);
    if (n_mismatch < MAX_REPORTS) $display("mismatch: %s", msg);
    n_mismatch++;
  endfunction

  // bin counts after one request, results left in pred_results
  function automatic void hist_predict(input in_item_t req);
    int unsigned n;
    int unsigned e;
    int unsigned idx;
    int unsigned i;
    logic [7:0]  expo;
    logic [VAL_W-1:0] mant;
    logic [VAL_W-1:0] t;
    bit ok;
    out_item_t res;
    n = (bin_count_model == '0) ? 1 :
        (bin_count_model > CNT_W'(MAX_BINS_DEF)) ? MAX_BINS_DEF : int'(bin_count_model);
    pred_results.delete();
    res = '0;
    res.last = 1'b1;
    case (req.action)
      ACT_ADD: begin
        expo = req.sample_bits[30:23];
        mant = {9'd1, req.sample_bits[22:0]};
        t = '0;
        ok = 1'b1;
        if (expo == 8'hFF) begin
          ok = 1'b0;
        end else if (expo >= 8'd127) begin
          // magnitude of at least one: sign and range decide
          e = int'(expo) - 127;
          if (req.sample_bits[31] || e >= 31) ok = 1'b0;
          else if (e >= 23) t = mant << (e - 23);
          else t = mant >> (23 - e);
        end
        if (!ok) begin
          res.status = ST_REJECTED;
        end else begin
          idx = (t == VAL_W'(n)) ? n - 1 : int'(t % VAL_W'(n));
          if (bin_model[idx] != '1) bin_model[idx]++;
          res.status    = ST_COUNTED;
          res.bin_index = BIN_IDX_W'(idx);
          res.bin_value = bin_model[idx];
        end
        pred_results.push_back(res);
      end
      ACT_CLEAR: begin
        foreach (bin_model[j]) bin_model[j] = '0;
        res.status = ST_CLEARED;
        pred_results.push_back(res);
      end
      ACT_DUMP: begin
        for (i = 0; i < n; i++) begin
          res.status    = ST_DUMP;
          res.bin_index = BIN_IDX_W'(i);
          res.bin_value = bin_model[i];
          res.last      = (i == n - 1);
          pred_results.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(input in_item_t req, input logic typed, input out_item_t typed_res);
    if (!quiet && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hist_predict(req);
    if (typed) exp_results.push_back(typed_res);
    else foreach (pred_results[k]) exp_results.push_back(pred_results[k]);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == ADDR_BIN_COUNT) bin_count_model = data[CNT_W-1:0];
    @(negedge clk);
    if (addr == ADDR_BIN_COUNT) begin
      // read back
      cfg_pwrite  <= 1'b0;
      cfg_penable <= 1'b0;
      @(negedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      if (cfg_prdata[CNT_W-1:0] !== bin_count_model)
        flag($sformatf("bin_count read %0d, want %0d", cfg_prdata[CNT_W-1:0],
                       bin_count_model));
      @(negedge clk);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_results.size() == 0) begin
        flag($sformatf("unexpected result st %0d bin %0d val %h last %b", out_data.status,
                       out_data.bin_index, out_data.bin_value, out_data.last));
      end else begin
        want = exp_results.pop_front();
        if (out_data.status !== want.status || out_data.bin_index !== want.bin_index ||
            out_data.bin_value !== want.bin_value || out_data.last !== want.last)
          flag($sformatf("got st %0d bin %0d val %h last %b, want st %0d bin %0d val %h last %b",
                         out_data.status, out_data.bin_index, out_data.bin_value,
                         out_data.last, want.status, want.bin_index, want.bin_value,
                         want.last));
      end
    end
  end

  initial begin : ready_drive
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYC) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 99) < ready_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin : main_seq
    logic [CNT_W-1:0] bin_count_plan [N_PHASES];
    in_item_t    req;
    int unsigned phase;
    int unsigned sent;
    int unsigned r;
    int unsigned v;
    int unsigned p;
    bin_count_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'd0, 5'd10};
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    foreach (bin_model[j]) bin_model[j] = '0;
    bin_count_model = BIN_COUNT_RST;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_ROWS[i]) send_req(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    drain();

    for (phase = 0; phase < N_PHASES; phase++) begin
      v = (phase == 6) ? $urandom_range(1, 16) : int'(bin_count_plan[phase]);
      cfg_write(ADDR_BIN_COUNT, (32'($urandom) & ~32'h1F) | 32'(v));
      // unmapped register must leave the bin count alone
      if (phase == 5) cfg_write(ADDR_UNMAPPED, 32'($urandom));
      quiet           = (phase == N_PHASES - 1);
      sender_idle_pct = quiet ? 0 : $urandom_range(0, 40);
      ready_idle_pct  = quiet ? 0 : $urandom_range(0, 40);
      if (phase == 1) long_hold = 1'b1;
      sent = 0;
      while (sent < REQS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        req.sample_bits = $urandom();
        if (r < 7) begin
          req.action = ACT_DUMP;
        end else if (r < 10) begin
          req.action = ACT_CLEAR;
        end else if (r < 13) begin
          req.action = ACT_NONE;
        end else begin
          req.action = ACT_ADD;
          case ($urandom_range(0, 9))
            0: ;
            1: req.sample_bits[30:23] = 8'($urandom_range(0, 126));
            2: req.sample_bits[30:23] = 8'($urandom_range(156, 255));
            3: begin
              // whole number: a value from 1 to 16 times one from 1 to 3
              v = $urandom_range(1, 16) * $urandom_range(1, 3);
              p = $clog2(v + 1) - 1;
              req.sample_bits = {1'b0, 8'(127 + p), 23'(v << (23 - p))};
            end
            default: begin
              req.sample_bits[31]    = 1'b0;
              req.sample_bits[30:23] = 8'($urandom_range(127, 132));
            end
          endcase
        end
        if (req.action != ACT_NONE) sent++;
        send_req(req, 1'b0, NO_RES);
      end
      drain();
    end

    if (n_mismatch == 0 && exp_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
